// ===== src/bfpa_pkg.sv =====
// Shared types, constants and controller interface structs for the best-fit page allocator.
`default_nettype none
package bfpa_pkg;

  localparam int unsigned MAX_BLOCKS_DEF      = 64;
  localparam int unsigned PAGE_INDEX_BITS_DEF = 20;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_ISSUE,
    S_SCAN_WAIT,
    S_SCAN_CHECK,
    S_DECIDE,
    S_SHIFT_ISSUE,
    S_SHIFT_WAIT,
    S_SHIFT_WRITE,
    S_APPLY,
    S_DONE
  } bfpa_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // capture the request
    logic scan_start;  // reset the scan index
    logic scan_rd;     // read entry at the scan index
    logic scan_step;   // evaluate the read entry and advance
    logic decide;      // choose the action after the scan
    logic shift_rd;    // read the source entry of a move
    logic shift_wr;    // write the moved entry and step
    logic apply;       // write the final entry and update totals
    logic finish;      // present the result
  } bfpa_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_last;   // the scan index has reached the entry count
    logic need_shift;  // a move of entries is needed
    logic shift_last;  // the last move has been done
    logic done_early;  // the request ends without touching the table
  } bfpa_stat_t;

endpackage
`default_nettype wire

// ===== src/bfpa_ctrl.sv =====
// Controller state machine sequencing scan, shift and update of the allocator.
`default_nettype none
module bfpa_ctrl
  import bfpa_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  bfpa_stat_t stat,
  output bfpa_cmd_t  cmd,
  output logic       busy
);

  bfpa_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN_ISSUE;
        end
      end
      S_SCAN_ISSUE: begin
        if (stat.scan_last) begin
          state_next = S_DECIDE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        state_next = S_SCAN_CHECK;
      end
      S_SCAN_CHECK: begin
        cmd.scan_step = 1'b1;
        state_next    = S_SCAN_ISSUE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_SHIFT_ISSUE;
      end
      S_SHIFT_ISSUE: begin
        if (stat.done_early) begin
          state_next = S_DONE;
        end else if (!stat.need_shift || stat.shift_last) begin
          state_next = S_APPLY;
        end else begin
          cmd.shift_rd = 1'b1;
          state_next   = S_SHIFT_WAIT;
        end
      end
      S_SHIFT_WAIT: begin
        state_next = S_SHIFT_WRITE;
      end
      S_SHIFT_WRITE: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SHIFT_ISSUE;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/bfpa_dp.sv =====
// Datapath: free-block table memory, scan evaluation, entry moves and totals.
`default_nettype none
module bfpa_dp
  import bfpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS      = MAX_BLOCKS_DEF,
  parameter int unsigned PAGE_INDEX_BITS = PAGE_INDEX_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  bfpa_cmd_t                   cmd,
  output bfpa_stat_t                  stat,
  input  wire  [1:0]                  opcode,
  input  wire  [PAGE_INDEX_BITS-1:0]  block_base,
  input  wire  [PAGE_INDEX_BITS:0]    page_count,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [PAGE_INDEX_BITS-1:0]  alloc_base,
  output logic [PAGE_INDEX_BITS:0]    free_total
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned PW = PAGE_INDEX_BITS;
  localparam int unsigned LW = PAGE_INDEX_BITS + 1;
  localparam logic [LW-1:0] SPACE = LW'(1) << PW;
  localparam logic [CW-1:0] FULL  = CW'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    A_NONE,
    A_INSERT,
    A_MODIFY,
    A_DELETE
  } act_t;

  // Table memory, one write and one registered read port.
  logic [PW-1:0] mem_start [MAX_BLOCKS];
  logic [LW-1:0] mem_len   [MAX_BLOCKS];
  logic [PW-1:0] rd_start;
  logic [LW-1:0] rd_len;
  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [PW-1:0] wr_start;
  logic [LW-1:0] wr_len;

  // The read data is held until the next read, so it stays valid while it waits.
  assign rd_en = cmd.scan_rd | cmd.shift_rd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_len[wr_addr]   <= wr_len;
    end
    if (rd_en) begin
      rd_start <= mem_start[rd_addr];
      rd_len   <= mem_len[rd_addr];
    end
  end

  // Request and scan state.
  logic [1:0]    op;
  logic [PW-1:0] base;
  logic [LW-1:0] cnt, len;
  logic [CW-1:0] count, scan_idx, pos, best;
  logic [CW-1:0] shift_idx, shift_end;
  logic          found, lo, hi, shift_up;
  logic [PW-1:0] best_start, lo_start, hi_start;
  logic [LW-1:0] best_len, lo_len, hi_len, total;
  logic          pos_done;
  act_t          act;
  logic [CW-1:0] act_idx;
  logic [PW-1:0] act_start;
  logic [LW-1:0] act_len;
  logic          early;

  logic [LW-1:0] room, clip_len;
  assign room     = SPACE - LW'(block_base);
  assign clip_len = (page_count > room) ? room : page_count;

  logic [LW:0] tsum;
  assign tsum = {1'b0, total} + {1'b0, (op == OP_ALLOC) ? LW'(0) : len};

  assign stat.scan_last  = (scan_idx == count);
  assign stat.need_shift = shift_up ? (shift_idx > shift_end) : (shift_idx < shift_end);
  assign stat.shift_last = !stat.need_shift;
  assign stat.done_early = early;

  // Read address: scan reads, then shift reads.
  always_comb begin
    rd_addr = IW'(scan_idx);
    if (cmd.shift_rd) begin
      rd_addr = shift_up ? IW'(shift_idx - CW'(1)) : IW'(shift_idx + CW'(1));
    end
  end

  // Write port: entry moves, then the final entry.
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = IW'(act_idx);
    wr_start = act_start;
    wr_len   = act_len;
    if (cmd.shift_wr) begin
      wr_en    = 1'b1;
      wr_addr  = IW'(shift_idx);
      wr_start = rd_start;
      wr_len   = rd_len;
    end else if (cmd.apply && (act == A_INSERT || act == A_MODIFY)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.apply) begin
        unique case (act)
          A_INSERT: count <= count + CW'(1);
          A_DELETE: count <= count - CW'(1);
          A_MODIFY: begin
            if (op == OP_FREE && lo && hi) count <= count - CW'(1);
          end
          default: ;
        endcase
        if (op == OP_ALLOC) begin
          total <= (total > cnt) ? total - cnt : '0;
        end else begin
          total <= (tsum > {1'b0, SPACE}) ? SPACE : tsum[LW-1:0];
        end
      end
    end
  end

  // Request capture, scan and decision.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= opcode;
      base     <= block_base;
      cnt      <= page_count;
      len      <= clip_len;
      found    <= 1'b0;
      pos_done <= 1'b0;
      pos      <= '0;
      best     <= '0;
      lo       <= 1'b0;
      hi       <= 1'b0;
      status   <= ST_OK;
      alloc_base <= '0;
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end
    if (cmd.scan_step) begin
      scan_idx <= scan_idx + CW'(1);
      // Best fit: smallest length that fits, lowest index wins ties.
      if (rd_len >= cnt && (!found || rd_len < best_len)) begin
        found      <= 1'b1;
        best       <= scan_idx;
        best_start <= rd_start;
        best_len   <= rd_len;
      end
      // Insertion point: first entry starting above the base.
      if (!pos_done) begin
        if (rd_start <= base) begin
          pos      <= scan_idx + CW'(1);
          lo_start <= rd_start;
          lo_len   <= rd_len;
        end else begin
          pos_done <= 1'b1;
          hi_start <= rd_start;
          hi_len   <= rd_len;
        end
      end
    end
    if (cmd.decide) begin
      early     <= 1'b0;
      act       <= A_NONE;
      shift_up  <= 1'b0;
      shift_idx <= '0;
      shift_end <= '0;
      if (cnt == '0 || op == 2'd3) begin
        early <= 1'b1;
      end else if (op == OP_ADD) begin
        if (count >= FULL) begin
          status <= ST_FULL;
          early  <= 1'b1;
        end else begin
          act       <= A_INSERT;
          act_idx   <= pos;
          act_start <= base;
          act_len   <= len;
          shift_up  <= 1'b1;
          shift_idx <= count;
          shift_end <= pos;
        end
      end else if (op == OP_ALLOC) begin
        if (!found || cnt > total) begin
          status <= ST_NO_FIT;
          early  <= 1'b1;
        end else begin
          alloc_base <= best_start;
          act_idx    <= best;
          if (best_len > cnt) begin
            act       <= A_MODIFY;
            act_start <= best_start + cnt[PW-1:0];
            act_len   <= best_len - cnt;
          end else begin
            act       <= A_DELETE;
            shift_idx <= best;
            shift_end <= count - CW'(1);
          end
        end
      end else begin
        logic l, h;
        l = (pos != '0) && ({2'b0, lo_start} + {1'b0, lo_len} == {2'b0, base});
        h = pos_done && ({2'b0, base} + {1'b0, len} == {2'b0, hi_start});
        lo <= l;
        hi <= h;
        if (l && h) begin
          act       <= A_MODIFY;
          act_idx   <= pos - CW'(1);
          act_start <= lo_start;
          act_len   <= lo_len + len + hi_len;
          shift_idx <= pos;
          shift_end <= count - CW'(1);
        end else if (l) begin
          act       <= A_MODIFY;
          act_idx   <= pos - CW'(1);
          act_start <= lo_start;
          act_len   <= lo_len + len;
        end else if (h) begin
          act       <= A_MODIFY;
          act_idx   <= pos;
          act_start <= base;
          act_len   <= hi_len + len;
        end else if (count >= FULL) begin
          status <= ST_FULL;
          early  <= 1'b1;
        end else begin
          act       <= A_INSERT;
          act_idx   <= pos;
          act_start <= base;
          act_len   <= len;
          shift_up  <= 1'b1;
          shift_idx <= count;
          shift_end <= pos;
        end
      end
    end
    if (cmd.shift_wr) begin
      shift_idx <= shift_up ? shift_idx - CW'(1) : shift_idx + CW'(1);
    end
  end

  assign free_total = total;

endmodule
`default_nettype wire

// ===== src/best_fit_page_allocator_core.sv =====
// Top level of the best-fit page allocator: controller and datapath.
// The request is handled in steps: a scan of every entry, a decision, any entry moves,
// then the final write and totals update; an ignored or refused request skips moves and write.
// Throughput: one transaction at a time; the next may be accepted in the strobe cycle.
// Synchronous reset empties the table (entry count and free total cleared).
// The receiver cannot stall: done marks each result for exactly one cycle.
`default_nettype none
module best_fit_page_allocator_core
  import bfpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS      = MAX_BLOCKS_DEF,
  parameter int unsigned PAGE_INDEX_BITS = PAGE_INDEX_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire  [1:0]                  opcode,
  input  wire  [PAGE_INDEX_BITS-1:0]  block_base,
  input  wire  [PAGE_INDEX_BITS:0]    page_count,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [PAGE_INDEX_BITS-1:0]  alloc_base,
  output logic [PAGE_INDEX_BITS:0]    free_total
);

  bfpa_cmd_t  cmd;
  bfpa_stat_t stat;

  bfpa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  bfpa_dp #(
    .MAX_BLOCKS     (MAX_BLOCKS),
    .PAGE_INDEX_BITS(PAGE_INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .opcode    (opcode),
    .block_base(block_base),
    .page_count(page_count),
    .done      (done),
    .status    (status),
    .alloc_base(alloc_base),
    .free_total(free_total)
  );

  // A transaction accepted while idle makes the block busy next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

  // The result strobe is one cycle wide and comes as busy falls.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while still busy");

  // A failed request never reports an allocation base.
  a_fail_base: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (alloc_base == '0))
    else $error("failed request reported a base");

endmodule
`default_nettype wire

// ===== bench/best_fit_page_allocator_core_tb.sv =====
// Self-checking testbench for the best-fit page allocator core.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_page_allocator_core_tb;
  import bfpa_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         TABLE_SIZE = MAX_BLOCKS_DEF;
  localparam longint     PAGE_SPACE = 64'd1 << PAGE_INDEX_BITS_DEF;
  localparam int         RANDOM_ITEMS = 1700;
  localparam longint     CYCLE_LIMIT  = 4000000;
  localparam int         DRAIN_CYCLES = 600;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [19:0] block_base;
  logic [20:0] page_count;
  logic        done;
  logic [1:0]  status;
  logic [19:0] alloc_base;
  logic [20:0] free_total;

  // Expected values typed into a directed row travel alongside the request.
  logic        pin_on;
  logic [1:0]  pin_status;
  logic [19:0] pin_base;
  logic [20:0] pin_total;

  best_fit_page_allocator_core u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .block_base (block_base),
    .page_count (page_count),
    .done       (done),
    .status     (status),
    .alloc_base (alloc_base),
    .free_total (free_total)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Free-block table as the allocator should hold it.
  longint free_start [TABLE_SIZE];
  longint free_len   [TABLE_SIZE];
  int     free_count;
  longint spare_pages;

  typedef struct packed {
    logic [1:0]  st;
    logic [19:0] ab;
    logic [20:0] ft;
  } answer_t;

  answer_t     answers_due[$];
  logic [40:0] granted[$];  // {base, count} of successful allocations
  int          mismatches;
  longint      cycles;
  int          idle_pct;

  // Inserts a slot at pos, moving later entries up by one.
  task automatic open_slot(input int pos);
    int i;
    for (i = free_count; i > pos; i--) begin
      free_start[i] = free_start[i-1];
      free_len[i]   = free_len[i-1];
    end
    free_count++;
  endtask

  task automatic close_slot(input int pos);
    int i;
    for (i = pos; i + 1 < free_count; i++) begin
      free_start[i] = free_start[i+1];
      free_len[i]   = free_len[i+1];
    end
    free_count--;
  endtask

  task automatic credit_pages(input longint len);
    spare_pages = (spare_pages + len > PAGE_SPACE) ? PAGE_SPACE : spare_pages + len;
  endtask

  // Applies one request to the expected table and returns status and base.
  task automatic allocate_predict(input logic [1:0] op, input logic [19:0] base,
                                  input logic [20:0] cnt, output logic [1:0] st,
                                  output logic [19:0] ab);
    longint len;
    longint b;
    longint c;
    int     pos;
    int     best;
    int     i;
    bit     found;
    bit     lo;
    bit     hi;
    b  = base;
    c  = cnt;
    st = ST_OK;
    ab = '0;
    len = (c > PAGE_SPACE - b) ? PAGE_SPACE - b : c;
    pos = 0;
    while (pos < free_count && free_start[pos] <= b) pos++;
    if (c == 0 || op == OP_UNUSED) begin
      // Ignored request: nothing changes.
    end else if (op == OP_ADD) begin
      if (free_count >= TABLE_SIZE) begin
        st = ST_FULL;
      end else begin
        open_slot(pos);
        free_start[pos] = b;
        free_len[pos]   = len;
        credit_pages(len);
      end
    end else if (op == OP_ALLOC) begin
      found = 0;
      best  = 0;
      if (c <= spare_pages) begin
        for (i = 0; i < free_count; i++) begin
          if (free_len[i] >= c && (!found || free_len[i] < free_len[best])) begin
            found = 1;
            best  = i;
          end
        end
      end
      if (!found) begin
        st = ST_NO_FIT;
      end else begin
        ab = free_start[best][19:0];
        if (free_len[best] > c) begin
          free_start[best] = (free_start[best] + c) & (PAGE_SPACE - 1);
          free_len[best]   = free_len[best] - c;
        end else begin
          close_slot(best);
        end
        spare_pages = (spare_pages > c) ? spare_pages - c : 0;
      end
    end else begin
      lo = pos > 0 && free_start[pos-1] + free_len[pos-1] == b;
      hi = pos < free_count && b + len == free_start[pos];
      if (lo && hi) begin
        free_len[pos-1] = (free_len[pos-1] + len + free_len[pos]) & (2*PAGE_SPACE - 1);
        close_slot(pos);
        credit_pages(len);
      end else if (lo) begin
        free_len[pos-1] = (free_len[pos-1] + len) & (2*PAGE_SPACE - 1);
        credit_pages(len);
      end else if (hi) begin
        free_start[pos] = b;
        free_len[pos]   = (free_len[pos] + len) & (2*PAGE_SPACE - 1);
        credit_pages(len);
      end else if (free_count >= TABLE_SIZE) begin
        st = ST_FULL;
      end else begin
        open_slot(pos);
        free_start[pos] = b;
        free_len[pos]   = len;
        credit_pages(len);
      end
    end
  endtask

  // Checks each result, then records the expectation of any accepted transaction.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    logic [1:0]  st;
    logic [19:0] ab;
    if (!rst) begin
      if (done) begin
        got = '{st: status, ab: alloc_base, ft: free_total};
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: status %0d base %h total %h",
                     status, alloc_base, free_total);
        end else begin
          want = answers_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result mismatch: expected %0d/%h/%h, got %0d/%h/%h",
                       want.st, want.ab, want.ft, got.st, got.ab, got.ft);
          end
        end
      end
      if (start && !busy) begin
        allocate_predict(opcode, block_base, page_count, st, ab);
        if (opcode == OP_ALLOC && st == ST_OK) granted.push_back({ab, page_count});
        if (pin_on) answers_due.push_back('{st: pin_status, ab: pin_base, ft: pin_total});
        else answers_due.push_back('{st: st, ab: ab, ft: spare_pages[20:0]});
      end
    end
  end

  // Guards against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Presents one transaction and holds it until the block takes it.
  task automatic issue(input logic [1:0] op, input logic [19:0] base,
                       input logic [20:0] cnt, input bit pin, input logic [1:0] st,
                       input logic [19:0] ab, input logic [20:0] ft);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start      <= 1'b1;
    opcode     <= op;
    block_base <= base;
    page_count <= cnt;
    pin_on     <= pin;
    pin_status <= st;
    pin_base   <= ab;
    pin_total  <= ft;
    do @(posedge clk); while (busy);
  endtask

  typedef struct {
    logic [1:0]  op;
    logic [19:0] base;
    logic [20:0] cnt;
    bit          pin;
    logic [1:0]  st;
    logic [19:0] ab;
    logic [20:0] ft;
  } plan_row_t;

  // Directed opening: empty table, ignored requests, extremes and merges.
  plan_row_t plan[20] = '{
    '{OP_ALLOC, 20'h0,     21'h1,      1, ST_NO_FIT, 20'h0,     21'h0},
    '{OP_ADD,   20'h10,    21'h0,      1, ST_OK,     20'h0,     21'h0},
    '{OP_UNUSED,20'h5,     21'h7,      1, ST_OK,     20'h0,     21'h0},
    '{OP_ADD,   20'h10,    21'd100,    1, ST_OK,     20'h0,     21'd100},
    '{OP_ADD,   20'hFFFFF, 21'h100000, 1, ST_OK,     20'h0,     21'd101},
    '{OP_ALLOC, 20'h0,     21'h100000, 1, ST_NO_FIT, 20'h0,     21'd101},
    '{OP_ALLOC, 20'h0,     21'h1,      1, ST_OK,     20'hFFFFF, 21'd100},
    '{OP_ALLOC, 20'hFFFFF, 21'd40,     1, ST_OK,     20'h10,    21'd60},
    '{OP_FREE,  20'h10,    21'd40,     0, ST_OK,     20'h0,     21'h0},
    '{OP_FREE,  20'h74,    21'd8,      0, ST_OK,     20'h0,     21'h0},
    '{OP_ADD,   20'h200,   21'd16,     0, ST_OK,     20'h0,     21'h0},
    '{OP_ADD,   20'h100,   21'd16,     0, ST_OK,     20'h0,     21'h0},
    '{OP_FREE,  20'h7C,    21'h84,     0, ST_OK,     20'h0,     21'h0},
    '{OP_ADD,   20'h200,   21'd5,      0, ST_OK,     20'h0,     21'h0},
    '{OP_ALLOC, 20'h0,     21'd5,      0, ST_OK,     20'h0,     21'h0},
    '{OP_FREE,  20'h0,     21'h100000, 0, ST_OK,     20'h0,     21'h0},
    '{OP_ADD,   20'hABCDE, 21'h0FFFFF, 0, ST_OK,     20'h0,     21'h0},
    '{OP_ALLOC, 20'h0,     21'h100000, 0, ST_OK,     20'h0,     21'h0},
    '{OP_FREE,  20'hFFFFF, 21'd3,      0, ST_OK,     20'h0,     21'h0},
    '{OP_FREE,  20'h300,   21'h0,      0, ST_OK,     20'h0,     21'h0}
  };

  initial begin
    int          n;
    int          pick;
    int          k;
    logic [1:0]  op;
    logic [19:0] base;
    logic [20:0] cnt;
    logic [40:0] grant;
    rst = 1'b1;  start = 1'b0;  opcode = '0;  block_base = '0;  page_count = '0;
    pin_on = 1'b0;  pin_status = '0;  pin_base = '0;  pin_total = '0;
    free_count = 0;  spare_pages = 0;  mismatches = 0;  cycles = 0;  idle_pct = 29;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k])
      issue(plan[k].op, plan[k].base, plan[k].cnt, plan[k].pin,
            plan[k].st, plan[k].ab, plan[k].ft);

    // Random requests in three thirds: sender idles sometimes, often, then not at all.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      idle_pct = (n < RANDOM_ITEMS / 3) ? 29 : (n < 2 * RANDOM_ITEMS / 3) ? 84 : 0;
      pick = $urandom_range(99);
      base = (pick % 3 == 0) ? 20'($urandom) : 20'($urandom_range(0, 4095));
      cnt  = ($urandom_range(9) == 0) ? 21'($urandom_range(1, 21'h100000))
                                      : 21'($urandom_range(1, 64));
      // Every so often, bunch up additions so that the table fills.
      if ((n / 200) % 2 == 1 && pick < 60) begin
        op = OP_ADD;
        cnt = 21'($urandom_range(1, 8));
      end else if (pick < 4) begin
        op  = (pick < 2) ? OP_UNUSED : 2'($urandom_range(0, 2));
        cnt = (pick < 2) ? 21'($urandom) : 21'h0;
      end else if (pick < 28) begin
        op = OP_ADD;
      end else if (pick < 62) begin
        op = OP_ALLOC;
        if ($urandom_range(3) == 0) cnt = 21'($urandom_range(1, 1024));
      end else begin
        op = OP_FREE;
        // Mostly hand back earlier allocations, whole or in part, to drive merges.
        if (granted.size() > 0 && pick < 92) begin
          k     = $urandom_range(0, granted.size() - 1);
          grant = granted[k];
          granted.delete(k);
          base = grant[40:21];
          cnt  = grant[20:0];
          if (pick > 85 && cnt > 1) cnt = 21'($urandom_range(1, cnt - 1));
        end
      end
      if ($urandom_range(199) == 0) cnt = 21'h100000;
      if ($urandom_range(199) == 0) base = 20'hFFFFF;
      issue(op, base, cnt, 1'b0, ST_OK, '0, '0);
    end

    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== best_fit_page_allocator_core.f =====
src/bfpa_pkg.sv
src/bfpa_ctrl.sv
src/bfpa_dp.sv
src/best_fit_page_allocator_core.sv
bench/best_fit_page_allocator_core_tb.sv
